// ===== hdl/ibpq_pkg.sv =====
// Package for the infrared beam period qualifier.
// Holds register indexes, register widths and reset values, and default widths.
// No dependencies; used by ir_beam_period_qualifier_top.
`default_nettype none

package ibpq_pkg;

    // Default widths for the top-level parameters
    localparam int PERIOD_WIDTH_DEF = 16;
    localparam int TOTAL_WIDTH_DEF  = 32;

    // Configuration port geometry
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 17;

    // Register field widths
    localparam int NOMINAL_WIDTH  = 16;
    localparam int CONFIRM_WIDTH  = 8;
    localparam int LOSS_WIDTH     = 17;
    localparam int POLARITY_WIDTH = 3;

    // Input word width
    localparam int IN_DATA_WIDTH = 8;

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_NOMINAL_PERIOD    = 3'd0,
        REG_PERIOD_TOLERANCE  = 3'd1,
        REG_CONFIRM_NEEDED    = 3'd2,
        REG_LOSS_TIMEOUT      = 3'd3,
        REG_ERROR_CLEARS      = 3'd4,
        REG_LED_SHOWS_LIGHT   = 3'd5,
        REG_PIN_POLARITY      = 3'd6
    } cfg_index_t;

    // Bit positions within the polarity register
    localparam int POL_BIT_NO  = 0;
    localparam int POL_BIT_NC  = 1;
    localparam int POL_BIT_LED = 2;

    // Register reset values
    localparam logic [NOMINAL_WIDTH-1:0]  NOMINAL_RESET   = 16'd1000;
    localparam logic [NOMINAL_WIDTH-1:0]  TOLERANCE_RESET = 16'd100;
    localparam logic [CONFIRM_WIDTH-1:0]  CONFIRM_RESET   = 8'd3;
    localparam logic [LOSS_WIDTH-1:0]     TIMEOUT_RESET   = 17'd20000;
    localparam logic                      ERR_CLR_RESET   = 1'b1;
    localparam logic                      LED_MODE_RESET  = 1'b0;
    localparam logic [POLARITY_WIDTH-1:0] POLARITY_RESET  = 3'd7;

endpackage

`default_nettype wire

// ===== hdl/ir_beam_period_qualifier_top.sv =====
// Infrared beam period qualifier, top level with configuration registers.
// Depends on ibpq_pkg for register indexes, widths and reset values.
//
// Usage:
//   Input channel (s_): one word per 1 us tick; s_tdata bit 0 is the comparator
//   falling-edge flag for that tick. Result channel (m_): one word per input
//   word, carrying the light state, the NO/NC/LED pin levels, the last measured
//   period with its window verdict, and three wrapping event totals.
//   Configuration: a write on cfg_wr_en loads register cfg_addr from
//   cfg_wr_data in the same edge; writes are meant to happen while idle.
// Results and throughput:
//   A word accepted at an edge has its result loaded into the result register
//   in that same edge. The filter state updates in that same edge, so one word
//   is taken every clock cycle while the result register is free or draining;
//   the rate is set only by the result register draining.
// Reset:
//   aresetn (synchronous, active low) restores the register defaults, stops
//   both timers, clears the filter and the totals, and empties the result
//   register.
// Stalls:
//   While a result waits and m_tready is low, s_tready drops and the input is
//   held off; when m_tready is high a new word may enter in the same cycle
//   that the waiting result leaves.
`default_nettype none

module ir_beam_period_qualifier_top #(
    parameter int PERIOD_WIDTH = ibpq_pkg::PERIOD_WIDTH_DEF,
    parameter int TOTAL_WIDTH  = ibpq_pkg::TOTAL_WIDTH_DEF,
    localparam int OUT_BITS    = 5 + PERIOD_WIDTH + 3 * TOTAL_WIDTH,
    localparam int OUT_WIDTH   = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [ibpq_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [ibpq_pkg::CFG_DATA_WIDTH-1:0] cfg_wr_data,
    // Input channel
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata, lowest bit up: falling_edge, zero padding
    input  wire logic [ibpq_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    // Result channel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata, lowest bit up: beam_present, no_pin, nc_pin, led_pin,
    // measured_period, measured_valid, edge_total, valid_total,
    // invalid_total, zero padding
    output logic [OUT_WIDTH-1:0]                     m_tdata
);

    localparam int NW   = ibpq_pkg::NOMINAL_WIDTH;
    localparam int CW   = ibpq_pkg::CONFIRM_WIDTH;
    localparam int LW   = ibpq_pkg::LOSS_WIDTH;
    localparam int CMPW = (PERIOD_WIDTH > NW + 1) ? PERIOD_WIDTH : NW + 1;

    // Configuration registers
    logic [NW-1:0]                         nominal_reg;
    logic [NW-1:0]                         tolerance_reg;
    logic [CW-1:0]                         confirm_needed_reg;
    logic [LW-1:0]                         timeout_reg;
    logic                                  err_clears_reg;
    logic                                  led_mode_reg;
    logic [ibpq_pkg::POLARITY_WIDTH-1:0]   polarity_reg;

    // Filter state and its next values
    logic                    ref_ready_reg,   ref_ready_next;
    logic [CW-1:0]           confirm_reg,     confirm_next;
    logic [PERIOD_WIDTH-1:0] period_cnt_reg,  period_cnt_next;
    logic                    period_run_reg,  period_run_next;
    logic                    period_ovf_reg,  period_ovf_next;
    logic [LW-1:0]           loss_cnt_reg,    loss_cnt_next;
    logic                    loss_run_reg,    loss_run_next;
    logic                    light_reg,       light_next;
    logic [PERIOD_WIDTH-1:0] last_period_reg, last_period_next;
    logic                    last_valid_reg,  last_valid_next;
    logic [TOTAL_WIDTH-1:0]  edges_reg,       edges_next;
    logic [TOTAL_WIDTH-1:0]  valids_reg,      valids_next;
    logic [TOTAL_WIDTH-1:0]  invalids_reg,    invalids_next;

    // Result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_WIDTH-1:0] m_tdata_reg,  m_tdata_next;

    // Window and tick helpers
    logic              in_accept;
    logic              edge_flag;
    logic [LW-1:0]     loss_limit;
    logic [LW-1:0]     loss_inc;
    logic [NW-1:0]     win_lo;
    logic [NW:0]       win_hi;
    logic [CMPW-1:0]   period_cmp;
    logic              in_window;
    logic              blocked;
    logic              led_on;
    logic              no_level;
    logic              nc_level;
    logic              led_level;

    // Handshake: a new word enters whenever the result register is free or draining
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign edge_flag = s_tdata[0];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Window bounds; the lower bound saturates at zero, the upper one carries
    assign win_lo     = (nominal_reg > tolerance_reg) ? (nominal_reg - tolerance_reg) : '0;
    assign win_hi     = {1'b0, nominal_reg} + {1'b0, tolerance_reg};
    assign loss_limit = (timeout_reg == '0) ? LW'(1) : timeout_reg;
    assign loss_inc   = loss_cnt_reg + LW'(1);

    // One tick of the filter: timers first, then a loss, then the edge
    always_comb begin
        ref_ready_next   = ref_ready_reg;
        confirm_next     = confirm_reg;
        period_cnt_next  = period_cnt_reg;
        period_run_next  = period_run_reg;
        period_ovf_next  = period_ovf_reg;
        loss_cnt_next    = loss_cnt_reg;
        loss_run_next    = loss_run_reg;
        light_next       = light_reg;
        last_period_next = last_period_reg;
        last_valid_next  = last_valid_reg;
        edges_next       = edges_reg;
        valids_next      = valids_reg;
        invalids_next    = invalids_reg;

        // Period counter wraps from all ones to zero and flags the overflow
        if (period_run_reg) begin
            if (period_cnt_reg == {PERIOD_WIDTH{1'b1}}) begin
                period_cnt_next = '0;
                period_ovf_next = 1'b1;
            end else begin
                period_cnt_next = period_cnt_reg + PERIOD_WIDTH'(1);
            end
        end

        // Loss timer; on expiry the whole filter falls back to blocked
        if (loss_run_reg) begin
            loss_cnt_next = loss_inc;
            if (loss_inc >= loss_limit) begin
                loss_run_next    = 1'b0;
                loss_cnt_next    = '0;
                period_run_next  = 1'b0;
                period_cnt_next  = '0;
                period_ovf_next  = 1'b0;
                ref_ready_next   = 1'b0;
                confirm_next     = '0;
                last_period_next = '0;
                last_valid_next  = 1'b0;
                light_next       = 1'b0;
            end
        end

        period_cmp = CMPW'(period_cnt_next);
        in_window  = (period_cmp >= CMPW'(win_lo)) && (period_cmp <= CMPW'(win_hi));

        // Edge handling: the first edge sets the reference, later ones measure
        if (edge_flag) begin
            edges_next = edges_reg + TOTAL_WIDTH'(1);
            if (!ref_ready_next) begin
                ref_ready_next   = 1'b1;
                last_period_next = '0;
                last_valid_next  = 1'b0;
                period_cnt_next  = '0;
                period_ovf_next  = 1'b0;
                period_run_next  = 1'b1;
                loss_cnt_next    = '0;
                loss_run_next    = 1'b1;
            end else begin
                last_period_next = period_cnt_next;
                if (!period_ovf_next && in_window) begin
                    last_valid_next = 1'b1;
                    loss_cnt_next   = '0;
                    loss_run_next   = 1'b1;
                    valids_next     = valids_reg + TOTAL_WIDTH'(1);
                    if (confirm_next < confirm_needed_reg) begin
                        confirm_next = confirm_next + CW'(1);
                    end
                    if (confirm_next >= confirm_needed_reg) begin
                        confirm_next = confirm_needed_reg;
                        light_next   = 1'b1;
                    end
                end else begin
                    last_valid_next = 1'b0;
                    invalids_next   = invalids_reg + TOTAL_WIDTH'(1);
                    if (err_clears_reg) begin
                        confirm_next = '0;
                    end
                end
                period_cnt_next = '0;
                period_ovf_next = 1'b0;
                period_run_next = 1'b1;
            end
        end
    end

    // Pin levels follow the new light state, LED mode and polarity
    assign blocked    = !light_next;
    assign led_on     = led_mode_reg ? light_next : blocked;
    assign no_level   = polarity_reg[ibpq_pkg::POL_BIT_NO]  ? blocked    : !blocked;
    assign nc_level   = polarity_reg[ibpq_pkg::POL_BIT_NC]  ? light_next : !light_next;
    assign led_level  = polarity_reg[ibpq_pkg::POL_BIT_LED] ? led_on     : !led_on;

    // Result word and its valid flag
    always_comb begin
        m_tdata_next  = OUT_WIDTH'({invalids_next, valids_next, edges_next,
                                    last_valid_next, last_period_next,
                                    led_level, nc_level, no_level, light_next});
        m_tvalid_next = m_tvalid_reg;
        if (in_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg        <= ibpq_pkg::NOMINAL_RESET;
            tolerance_reg      <= ibpq_pkg::TOLERANCE_RESET;
            confirm_needed_reg <= ibpq_pkg::CONFIRM_RESET;
            timeout_reg        <= ibpq_pkg::TIMEOUT_RESET;
            err_clears_reg     <= ibpq_pkg::ERR_CLR_RESET;
            led_mode_reg       <= ibpq_pkg::LED_MODE_RESET;
            polarity_reg       <= ibpq_pkg::POLARITY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ibpq_pkg::REG_NOMINAL_PERIOD: begin
                    nominal_reg <= cfg_wr_data[NW-1:0];
                end
                ibpq_pkg::REG_PERIOD_TOLERANCE: begin
                    tolerance_reg <= cfg_wr_data[NW-1:0];
                end
                ibpq_pkg::REG_CONFIRM_NEEDED: begin
                    confirm_needed_reg <= cfg_wr_data[CW-1:0];
                end
                ibpq_pkg::REG_LOSS_TIMEOUT: begin
                    timeout_reg <= cfg_wr_data[LW-1:0];
                end
                ibpq_pkg::REG_ERROR_CLEARS: begin
                    err_clears_reg <= cfg_wr_data[0];
                end
                ibpq_pkg::REG_LED_SHOWS_LIGHT: begin
                    led_mode_reg <= cfg_wr_data[0];
                end
                ibpq_pkg::REG_PIN_POLARITY: begin
                    polarity_reg <= cfg_wr_data[ibpq_pkg::POLARITY_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Filter state advances once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_ready_reg   <= 1'b0;
            confirm_reg     <= '0;
            period_cnt_reg  <= '0;
            period_run_reg  <= 1'b0;
            period_ovf_reg  <= 1'b0;
            loss_cnt_reg    <= '0;
            loss_run_reg    <= 1'b0;
            light_reg       <= 1'b0;
            last_period_reg <= '0;
            last_valid_reg  <= 1'b0;
            edges_reg       <= '0;
            valids_reg      <= '0;
            invalids_reg    <= '0;
        end else if (in_accept) begin
            ref_ready_reg   <= ref_ready_next;
            confirm_reg     <= confirm_next;
            period_cnt_reg  <= period_cnt_next;
            period_run_reg  <= period_run_next;
            period_ovf_reg  <= period_ovf_next;
            loss_cnt_reg    <= loss_cnt_next;
            loss_run_reg    <= loss_run_next;
            light_reg       <= light_next;
            last_period_reg <= last_period_next;
            last_valid_reg  <= last_valid_next;
            edges_reg       <= edges_next;
            valids_reg      <= valids_next;
            invalids_reg    <= invalids_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Light can only be present while a reference edge is held
    a_light_needs_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        light_reg |-> ref_ready_reg)
        else $error("light present without a reference edge");

    // Both timers run only after a reference edge
    a_timers_need_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        (loss_run_reg || period_run_reg) |-> ref_ready_reg)
        else $error("timer running without a reference edge");

    // Every accepted word leaves a result behind
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid_reg)
        else $error("accepted word produced no result");

    // An accepted edge bumps the edge total by exactly one
    a_edge_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && edge_flag) |=> (edges_reg == $past(edges_reg) + TOTAL_WIDTH'(1)))
        else $error("edge total did not advance on an edge");

    // Valid and invalid totals never both move on one word
    a_one_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !((valids_reg != $past(valids_reg))
                        && (invalids_reg != $past(invalids_reg))))
        else $error("one word counted both valid and invalid");

endmodule

`default_nettype wire

// ===== sim/tb_ir_beam_period_qualifier_top.sv =====
// Self-checking testbench for the infrared beam period qualifier top level.
// Predicts every result word from the tick stream and the register settings it writes.
// Depends on ibpq_pkg and ir_beam_period_qualifier_top.

module tb_ir_beam_period_qualifier_top;

    localparam int PW           = ibpq_pkg::PERIOD_WIDTH_DEF;
    localparam int TW           = ibpq_pkg::TOTAL_WIDTH_DEF;
    localparam int NOMW         = ibpq_pkg::NOMINAL_WIDTH;
    localparam int CONFW        = ibpq_pkg::CONFIRM_WIDTH;
    localparam int LOSSW        = ibpq_pkg::LOSS_WIDTH;
    localparam int POLW         = ibpq_pkg::POLARITY_WIDTH;
    localparam int DATAW        = ibpq_pkg::CFG_DATA_WIDTH;
    localparam int INW          = ibpq_pkg::IN_DATA_WIDTH;
    localparam int STATUS_BITS  = 5 + PW + 3 * TW;
    localparam int STATUS_WIDTH = ((STATUS_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam logic [PW-1:0] PERIOD_MAX = '1;

    // One result word, lowest bit up: beam_present, no_pin, nc_pin, led_pin,
    // measured_period, measured_valid, edge_total, valid_total, invalid_total
    typedef struct packed {
        logic [TW-1:0] invalid_total;
        logic [TW-1:0] valid_total;
        logic [TW-1:0] edge_total;
        logic          measured_valid;
        logic [PW-1:0] measured_period;
        logic          led_pin;
        logic          nc_pin;
        logic          no_pin;
        logic          beam_present;
    } beam_status_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [ibpq_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [DATAW-1:0]                    cfg_wr_data;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [INW-1:0]                      s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [STATUS_WIDTH-1:0]             m_tdata;

    // Register copies held by the predictor
    logic [NOMW-1:0]  cfg_nominal    = ibpq_pkg::NOMINAL_RESET;
    logic [NOMW-1:0]  cfg_tol        = ibpq_pkg::TOLERANCE_RESET;
    logic [CONFW-1:0] cfg_confirm    = ibpq_pkg::CONFIRM_RESET;
    logic [LOSSW-1:0] cfg_timeout    = ibpq_pkg::TIMEOUT_RESET;
    logic             cfg_err_clears = ibpq_pkg::ERR_CLR_RESET;
    logic             cfg_led_light  = ibpq_pkg::LED_MODE_RESET;
    logic [POLW-1:0]  cfg_polarity   = ibpq_pkg::POLARITY_RESET;

    // Beam filter state held by the predictor
    logic             ref_armed      = 1'b0;
    logic [CONFW-1:0] confirm_cnt    = '0;
    logic [PW-1:0]    period_cnt     = '0;
    logic             period_run     = 1'b0;
    logic             period_wrapped = 1'b0;
    logic [LOSSW-1:0] loss_cnt       = '0;
    logic             loss_run       = 1'b0;
    logic             light_on       = 1'b0;
    logic [PW-1:0]    last_period    = '0;
    logic             last_ok        = 1'b0;
    logic [TW-1:0]    edges          = '0;
    logic [TW-1:0]    valids         = '0;
    logic [TW-1:0]    invalids       = '0;

    beam_status_t status_due[$];
    beam_status_t want_status;
    beam_status_t got_status;
    int           error_count = 0;
    bit           idle_gaps   = 1'b1;
    int           hold_seq    = 0;
    int           hold_len    = 0;

    ir_beam_period_qualifier_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle stretch length: mostly none, sometimes short, now and then long
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the predicted filter by one tick and queue the word it should produce
    task automatic advance_beam_tick(input logic fe);
        logic [LOSSW-1:0] loss_limit;
        logic [PW:0]      win_lo;
        logic [PW:0]      win_hi;
        logic [PW-1:0]    span;
        logic             wrapped;
        logic             blocked;
        beam_status_t     st;
        // The period counter wraps to zero at the top and remembers that it did
        if (period_run) begin
            if (period_cnt == PERIOD_MAX) begin
                period_cnt     = '0;
                period_wrapped = 1'b1;
            end else begin
                period_cnt = period_cnt + 1'b1;
            end
        end
        // Loss timer runs before the edge is looked at; a zero timeout acts as one
        if (loss_run) begin
            loss_cnt   = loss_cnt + 1'b1;
            loss_limit = (cfg_timeout == '0) ? LOSSW'(1) : cfg_timeout;
            if (loss_cnt >= loss_limit) begin
                loss_run       = 1'b0;
                loss_cnt       = '0;
                period_run     = 1'b0;
                period_cnt     = '0;
                period_wrapped = 1'b0;
                ref_armed      = 1'b0;
                confirm_cnt    = '0;
                last_period    = '0;
                last_ok        = 1'b0;
                light_on       = 1'b0;
            end
        end
        if (fe) begin
            edges = edges + 1'b1;
            if (!ref_armed) begin
                // First edge only arms the measurement
                ref_armed      = 1'b1;
                last_period    = '0;
                last_ok        = 1'b0;
                period_cnt     = '0;
                period_wrapped = 1'b0;
                period_run     = 1'b1;
                loss_cnt       = '0;
                loss_run       = 1'b1;
            end else begin
                span           = period_cnt;
                wrapped        = period_wrapped;
                period_cnt     = '0;
                period_wrapped = 1'b0;
                period_run     = 1'b1;
                last_period    = span;
                // Lower bound stops at zero, upper bound carries into the extra bit
                win_lo = (cfg_nominal > cfg_tol) ? {1'b0, cfg_nominal - cfg_tol} : '0;
                win_hi = {1'b0, cfg_nominal} + {1'b0, cfg_tol};
                if (!wrapped && {1'b0, span} >= win_lo && {1'b0, span} <= win_hi) begin
                    last_ok  = 1'b1;
                    loss_cnt = '0;
                    loss_run = 1'b1;
                    valids   = valids + 1'b1;
                    if (confirm_cnt < cfg_confirm) confirm_cnt = confirm_cnt + 1'b1;
                    if (confirm_cnt >= cfg_confirm) begin
                        confirm_cnt = cfg_confirm;
                        light_on    = 1'b1;
                    end
                end else begin
                    last_ok  = 1'b0;
                    invalids = invalids + 1'b1;
                    if (cfg_err_clears) confirm_cnt = '0;
                end
            end
        end
        // Pin levels follow the light state through mode and polarity
        blocked            = ~light_on;
        st.beam_present    = light_on;
        st.no_pin          = cfg_polarity[ibpq_pkg::POL_BIT_NO] ? blocked : ~blocked;
        st.nc_pin          = cfg_polarity[ibpq_pkg::POL_BIT_NC] ? light_on : ~light_on;
        st.led_pin         = (cfg_led_light ? light_on : blocked)
                             ^ ~cfg_polarity[ibpq_pkg::POL_BIT_LED];
        st.measured_period = last_period;
        st.measured_valid  = last_ok;
        st.edge_total      = edges;
        st.valid_total     = valids;
        st.invalid_total   = invalids;
        status_due.push_back(st);
    endtask

    // Offer one tick word, wait for it to be taken, then predict its result
    task automatic send_tick(input logic fe);
        int gap;
        gap = idle_gaps ? idle_span() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(INW-1){1'b0}}, fe};
        do @(posedge aclk); while (!s_tready);
        advance_beam_tick(fe);
    endtask

    // Quiet ticks followed by an edge, so the edge lands span ticks after the last one
    task automatic send_period(input int span);
        repeat (span - 1) send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    // Register writes only happen once every result word is back
    task automatic write_reg(input ibpq_pkg::cfg_index_t idx, input int value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value[DATAW-1:0];
        @(posedge aclk);
        case (idx)
            ibpq_pkg::REG_NOMINAL_PERIOD:   cfg_nominal    = value[NOMW-1:0];
            ibpq_pkg::REG_PERIOD_TOLERANCE: cfg_tol        = value[NOMW-1:0];
            ibpq_pkg::REG_CONFIRM_NEEDED:   cfg_confirm    = value[CONFW-1:0];
            ibpq_pkg::REG_LOSS_TIMEOUT:     cfg_timeout    = value[LOSSW-1:0];
            ibpq_pkg::REG_ERROR_CLEARS:     cfg_err_clears = value[0];
            ibpq_pkg::REG_LED_SHOWS_LIGHT:  cfg_led_light  = value[0];
            ibpq_pkg::REG_PIN_POLARITY:     cfg_polarity   = value[POLW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_window(input int nom, input int tol, input int conf, input int tmo);
        write_reg(ibpq_pkg::REG_NOMINAL_PERIOD, nom);
        write_reg(ibpq_pkg::REG_PERIOD_TOLERANCE, tol);
        write_reg(ibpq_pkg::REG_CONFIRM_NEEDED, conf);
        write_reg(ibpq_pkg::REG_LOSS_TIMEOUT, tmo);
    endtask

    task automatic compare_field(input string name, input logic [TW-1:0] want,
                                 input logic [TW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Check every result word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                $error("result word arrived with no tick outstanding");
                error_count++;
            end else begin
                want_status = status_due.pop_front();
                got_status  = m_tdata[STATUS_BITS-1:0];
                compare_field("beam_present", TW'(want_status.beam_present),
                              TW'(got_status.beam_present));
                compare_field("no_pin", TW'(want_status.no_pin), TW'(got_status.no_pin));
                compare_field("nc_pin", TW'(want_status.nc_pin), TW'(got_status.nc_pin));
                compare_field("led_pin", TW'(want_status.led_pin), TW'(got_status.led_pin));
                compare_field("measured_period", TW'(want_status.measured_period),
                              TW'(got_status.measured_period));
                compare_field("measured_valid", TW'(want_status.measured_valid),
                              TW'(got_status.measured_valid));
                compare_field("edge_total", want_status.edge_total, got_status.edge_total);
                compare_field("valid_total", want_status.valid_total, got_status.valid_total);
                compare_field("invalid_total", want_status.invalid_total,
                              got_status.invalid_total);
                compare_field("padding", '0, TW'(m_tdata[STATUS_WIDTH-1:STATUS_BITS]));
            end
        end
    end

    // Result side: random stalls, plus a long hold whenever a test asks for one
    initial begin : result_sink
        int stall;
        int served;
        stall    = 0;
        served   = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall == 0 && served != hold_seq) begin
                served = hold_seq;
                stall  = hold_len;
            end else if (stall == 0 && idle_gaps && $urandom_range(0, 99) < 25) begin
                stall = idle_span();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_ir_beam_period_qualifier_top: FAIL");
        $finish;
    end

    // Default registers straight out of reset; the window is far from these periods
    task automatic test_after_reset();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_period(3);
        send_tick(1'b0);
    endtask

    task automatic test_window_bounds();
        write_reg(ibpq_pkg::REG_ERROR_CLEARS, 1);
        set_window(4, 1, 2, 40);
        send_tick(1'b1);
        // Both edges of the window, then one tick beyond each
        send_period(3);
        send_period(5);
        send_period(2);
        send_period(6);
        // Tolerance above nominal: lower bound stops at zero
        set_window(2, 5, 1, 40);
        send_period(1);
        send_period(7);
        send_period(8);
        // Widest window: the upper bound must not wrap
        set_window(16'hFFFF, 16'hFFFF, 1, 40);
        send_period(9);
        // Zero nominal and tolerance: nothing fits
        set_window(0, 0, 1, 40);
        send_period(1);
    endtask

    task automatic test_confirm_rules();
        // Zero confirm count: the first valid period turns the light on
        set_window(3, 0, 0, 20);
        send_tick(1'b1);
        send_period(3);
        repeat (25) send_tick(1'b0);
        // Errors leave the count alone when clearing is off
        write_reg(ibpq_pkg::REG_ERROR_CLEARS, 0);
        set_window(3, 0, 3, 20);
        send_tick(1'b1);
        send_period(3);
        send_period(3);
        send_period(5);
        send_period(3);
        repeat (25) send_tick(1'b0);
        // ... and restart it when clearing is on
        write_reg(ibpq_pkg::REG_ERROR_CLEARS, 1);
        send_tick(1'b1);
        send_period(3);
        send_period(3);
        send_period(5);
        repeat (3) send_period(3);
        repeat (25) send_tick(1'b0);
        // Limit lowered below the count reached: clamped at the next valid period
        set_window(3, 0, 5, 20);
        send_tick(1'b1);
        repeat (3) send_period(3);
        write_reg(ibpq_pkg::REG_CONFIRM_NEEDED, 2);
        send_period(3);
        repeat (25) send_tick(1'b0);
        // Full-scale confirm count
        set_window(1, 0, 255, 20);
        repeat (261) send_tick(1'b1);
    endtask

    task automatic test_pin_levels();
        int mode;
        int pol;
        // Each setting sees the light come on and then drop after a short loss timeout
        set_window(1, 0, 0, 2);
        for (mode = 0; mode < 2; mode++) begin
            for (pol = 0; pol < 8; pol++) begin
                write_reg(ibpq_pkg::REG_LED_SHOWS_LIGHT, mode);
                write_reg(ibpq_pkg::REG_PIN_POLARITY, pol);
                send_tick(1'b1);
                send_tick(1'b1);
                send_tick(1'b0);
                send_tick(1'b0);
            end
        end
    endtask

    task automatic test_loss_timeout();
        // Zero timeout acts as one; every edge then meets a loss and re-arms
        set_window(1, 0, 0, 0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(ibpq_pkg::REG_LOSS_TIMEOUT, 1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        // Edge in the very tick the loss lands becomes a fresh reference
        set_window(2, 0, 1, 5);
        send_tick(1'b1);
        send_period(2);
        send_period(5);
        send_period(2);
        repeat (8) send_tick(1'b0);
        // A longer timeout run flat out until the loss lands
        idle_gaps = 1'b0;
        set_window(2, 0, 1, 120);
        send_tick(1'b1);
        send_period(2);
        repeat (123) send_tick(1'b0);
        idle_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        int k;
        set_window(4, 1, 2, 30);
        // Long hold on the result side while ticks keep coming
        idle_gaps = 1'b0;
        hold_len  = 300;
        hold_seq++;
        for (k = 0; k < 20; k++) send_period($urandom_range(3, 5));
        // Sender waits for every outstanding word before carrying on
        wait_drained();
        idle_gaps = 1'b1;
        for (k = 0; k < 10; k++) send_period($urandom_range(2, 6));
    endtask

    task automatic test_random_phases();
        int phase;
        int k;
        int nom;
        int tol;
        int conf;
        int tmo;
        int lo_i;
        int hi_i;
        int plo;
        int phi;
        int p;
        int run;
        int sent;
        for (phase = 0; phase < 10; phase++) begin
            // Window: mostly small and reachable, sometimes at the extremes
            k = $urandom_range(0, 9);
            case (k)
                0: begin nom = 0;     tol = $urandom_range(0, 3); end
                1: begin nom = 65535; tol = 65535; end
                2: begin nom = 65535; tol = 0; end
                3: begin nom = $urandom_range(1, 30); tol = 65535; end
                default: begin nom = $urandom_range(1, 30); tol = $urandom_range(0, 4); end
            endcase
            k    = $urandom_range(0, 9);
            conf = (k == 0) ? 255 : (k == 1) ? $urandom_range(0, 255) : $urandom_range(0, 5);
            k    = $urandom_range(0, 19);
            tmo  = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? 65536 : $urandom_range(8, 250);
            set_window(nom, tol, conf, tmo);
            write_reg(ibpq_pkg::REG_ERROR_CLEARS, $urandom_range(0, 1));
            write_reg(ibpq_pkg::REG_LED_SHOWS_LIGHT, $urandom_range(0, 1));
            write_reg(ibpq_pkg::REG_PIN_POLARITY, $urandom_range(0, 7));
            idle_gaps = ($urandom_range(0, 3) != 0);
            lo_i = (nom > tol) ? nom - tol : 0;
            hi_i = nom + tol;
            plo  = (lo_i > 1) ? lo_i : 1;
            phi  = (hi_i < 60) ? hi_i : 60;
            sent = 0;
            while (sent < 65) begin
                if ($urandom_range(0, 99) < 75) begin
                    // Edge trains, mostly inside the window and often on its bounds
                    k = $urandom_range(0, 99);
                    if (plo <= phi && k < 80) begin
                        if (k < 15) p = plo;
                        else if (k < 30) p = phi;
                        else p = $urandom_range(plo, phi);
                    end else if (k < 90 && lo_i > 1 && lo_i <= 61) begin
                        p = lo_i - 1;
                    end else if (k < 95 && hi_i < 60) begin
                        p = hi_i + 1;
                    end else begin
                        p = $urandom_range(1, 60);
                    end
                    send_period(p);
                    sent += p;
                end else begin
                    // Noise: edges scattered at random
                    run = $urandom_range(1, 20);
                    repeat (run) send_tick($urandom_range(0, 99) < 30);
                    sent += run;
                end
            end
        end
        idle_gaps = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_window_bounds();
        test_confirm_rules();
        test_pin_levels();
        test_loss_timeout();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_ir_beam_period_qualifier_top: PASS");
        end else begin
            $display("tb_ir_beam_period_qualifier_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== ir_beam_period_qualifier_top.f =====
hdl/ibpq_pkg.sv
hdl/ir_beam_period_qualifier_top.sv
sim/tb_ir_beam_period_qualifier_top.sv
